// ===== src/nsf_pkg.sv =====
// nsf_pkg: types, character codes and helpers for the NMEA sentence framer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

    // Default limits on the command and data parts
    localparam int CMD_MAX_DEF  = 8;
    localparam int DATA_MAX_DEF = 128;

    // Command store geometry (fixed by the 64-bit command word)
    localparam int CMD_DEPTH = 8;
    localparam int CMD_IDX_W = $clog2(CMD_DEPTH);

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 3;
    localparam int LEN_W    = 4;
    localparam int SKIP_W   = 4;
    localparam int WORD_W   = CMD_DEPTH * BYTE_W;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_START  = 8'h24; // '$'
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C; // ','
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A; // '*'
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D; // carriage return
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39; // '9'
    localparam logic [BYTE_W-1:0] CH_UPPERA = 8'h41; // 'A'

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CMD  = 3'd1,
        PH_DATA = 3'd2,
        PH_CK1  = 3'd3,
        PH_CK2  = 3'd4
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_CK_OK    = 3'd2,
        ST_CK_BAD   = 3'd3,
        ST_CR_END   = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [CLASS_W-1:0] {
        CL_IGNORED = 3'd0,
        CL_START   = 3'd1,
        CL_SKIPPED = 3'd2,
        CL_CMD     = 3'd3,
        CL_SEP     = 3'd4,
        CL_DATA    = 3'd5,
        CL_CKSUM   = 3'd6
    } t_class;

    // Hex digit value: decimal digits directly, anything else as letter (mod 16)
    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                d = b - CH_ZERO;
            end else begin
                d = b - CH_UPPERA + 8'd10;
            end
            return d[3:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/nsf_if.sv =====
// Valid/ready channel interfaces for the NMEA sentence framer:
// received bytes, per-byte results and the skip configuration. Uses nsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel
interface nsf_in_if;
    logic                        valid;
    logic                        ready;
    logic [nsf_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Per-byte result channel
interface nsf_out_if;
    logic                          valid;
    logic                          ready;
    logic [nsf_pkg::STATUS_W-1:0]  status;
    logic [nsf_pkg::CLASS_W-1:0]   byte_class;
    logic [nsf_pkg::BYTE_W-1:0]    field_index;
    logic [nsf_pkg::WORD_W-1:0]    command_word;
    logic [nsf_pkg::LEN_W-1:0]     command_length;
    logic [nsf_pkg::BYTE_W-1:0]    computed_checksum;
    logic [nsf_pkg::BYTE_W-1:0]    received_checksum;

    modport source (output valid, output status, output byte_class, output field_index,
                    output command_word, output command_length,
                    output computed_checksum, output received_checksum, input ready);
    modport sink   (input valid, input status, input byte_class, input field_index,
                    input command_word, input command_length,
                    input computed_checksum, input received_checksum, output ready);
endinterface

// Configuration write channel (skip count after the start character)
interface nsf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [nsf_pkg::SKIP_W-1:0]  skip_after_start;

    modport source (output valid, output skip_after_start, input ready);
    modport sink   (input valid, input skip_after_start, output ready);
endinterface

`default_nettype wire

// ===== src/nmea_sentence_framer.sv =====
// NMEA sentence framer top level: per-byte framing, XOR checksum and result register.
// Depends on nsf_pkg and the channel interfaces in nsf_if.sv.
//
//  Channel | Dir | Payload                                         | Transfer when
//  i_in    | in  | rx_byte                                         | valid & ready
//  o_out   | out | status, byte_class, field_index, command_word,   | valid & ready
//          |     | command_length, computed_checksum, received_csum|
//  i_cfg   | in  | skip_after_start                                | valid & ready
//
// One byte per cycle; each byte's result appears in the output register in the cycle
// after its transfer. The framing state updates in the same cycle as the transfer.
// i_in.ready is low only while a result is held and o_out.ready is low.
// Synchronous active-low reset clears the phase, counters, checksum and command store.
// i_cfg is always ready; the register takes effect from the next byte.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer #(
    parameter int CMD_MAX  = nsf_pkg::CMD_MAX_DEF,
    parameter int DATA_MAX = nsf_pkg::DATA_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    nsf_in_if.sink      i_in,
    nsf_cfg_if.sink     i_cfg,
    nsf_out_if.source   o_out
);

    localparam int BW = nsf_pkg::BYTE_W;

    // Framing state
    nsf_pkg::t_phase                  r_phase, n_phase;
    logic [BW-1:0]                    r_xor, n_xor;
    logic [BW-1:0]                    r_hex, n_hex;
    logic [BW-1:0]                    r_pos, n_pos;
    logic [nsf_pkg::SKIP_W-1:0]       r_skip_cnt, n_skip_cnt;
    logic [nsf_pkg::LEN_W-1:0]        r_cmd_len, n_cmd_len;
    logic [BW-1:0]                    r_cmd [nsf_pkg::CMD_DEPTH];
    logic [BW-1:0]                    n_cmd [nsf_pkg::CMD_DEPTH];
    logic [nsf_pkg::SKIP_W-1:0]       r_skip_cfg;

    // Result register
    logic                             r_out_valid;
    nsf_pkg::t_status                 r_status, n_status;
    nsf_pkg::t_class                  r_class, n_class;
    logic [BW-1:0]                    r_idx, n_idx;
    logic [nsf_pkg::WORD_W-1:0]       r_word, n_word;

    logic          in_xfer;
    logic [BW-1:0] b;

    assign b           = i_in.rx_byte;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Per-byte framing decision
    always_comb begin
        n_phase    = r_phase;
        n_xor      = r_xor;
        n_hex      = r_hex;
        n_pos      = r_pos;
        n_skip_cnt = r_skip_cnt;
        n_cmd_len  = r_cmd_len;
        n_cmd      = r_cmd;
        n_status   = nsf_pkg::ST_IDLE;
        n_class    = nsf_pkg::CL_IGNORED;
        n_idx      = '0;
        case (r_phase)
            nsf_pkg::PH_IDLE: begin
                if (b == nsf_pkg::CH_START) begin
                    n_xor      = '0;
                    n_hex      = '0;
                    n_pos      = '0;
                    n_skip_cnt = '0;
                    n_cmd_len  = '0;
                    for (int i = 0; i < nsf_pkg::CMD_DEPTH; i++) begin
                        n_cmd[i] = '0;
                    end
                    n_phase  = nsf_pkg::PH_CMD;
                    n_status = nsf_pkg::ST_BUSY;
                    n_class  = nsf_pkg::CL_START;
                end
            end
            nsf_pkg::PH_CMD: begin
                if (r_skip_cnt < r_skip_cfg) begin
                    n_idx      = BW'(r_skip_cnt);
                    n_skip_cnt = r_skip_cnt + 1'b1;
                    n_status   = nsf_pkg::ST_BUSY;
                    n_class    = nsf_pkg::CL_SKIPPED;
                end else if (b inside {nsf_pkg::CH_COMMA, nsf_pkg::CH_STAR}) begin
                    n_idx = BW'(r_cmd_len);
                    if (b == nsf_pkg::CH_COMMA) begin
                        n_xor   = r_xor ^ b;
                        n_phase = nsf_pkg::PH_DATA;
                    end else begin
                        n_phase = nsf_pkg::PH_CK1;
                    end
                    n_pos    = '0;
                    n_status = nsf_pkg::ST_BUSY;
                    n_class  = nsf_pkg::CL_SEP;
                end else begin
                    n_xor   = r_xor ^ b;
                    n_idx   = BW'(r_cmd_len);
                    n_class = nsf_pkg::CL_CMD;
                    if (r_cmd_len >= nsf_pkg::LEN_W'(CMD_MAX)) begin
                        n_phase  = nsf_pkg::PH_IDLE;
                        n_status = nsf_pkg::ST_OVERFLOW;
                    end else begin
                        n_cmd[r_cmd_len[nsf_pkg::CMD_IDX_W-1:0]] = b;
                        n_cmd_len = r_cmd_len + 1'b1;
                        n_status  = nsf_pkg::ST_BUSY;
                    end
                end
            end
            nsf_pkg::PH_DATA: begin
                n_idx = r_pos;
                if (b == nsf_pkg::CH_STAR) begin
                    n_phase  = nsf_pkg::PH_CK1;
                    n_status = nsf_pkg::ST_BUSY;
                    n_class  = nsf_pkg::CL_SEP;
                end else if (b == nsf_pkg::CH_CR) begin
                    n_phase  = nsf_pkg::PH_IDLE;
                    n_status = nsf_pkg::ST_CR_END;
                    n_class  = nsf_pkg::CL_SEP;
                end else begin
                    n_xor   = r_xor ^ b;
                    n_class = nsf_pkg::CL_DATA;
                    if (r_pos >= BW'(DATA_MAX)) begin
                        n_phase  = nsf_pkg::PH_IDLE;
                        n_status = nsf_pkg::ST_OVERFLOW;
                    end else begin
                        n_pos    = r_pos + 1'b1;
                        n_status = nsf_pkg::ST_BUSY;
                    end
                end
            end
            nsf_pkg::PH_CK1: begin
                n_hex    = {nsf_pkg::hex_nibble(b), 4'h0};
                n_phase  = nsf_pkg::PH_CK2;
                n_status = nsf_pkg::ST_BUSY;
                n_class  = nsf_pkg::CL_CKSUM;
            end
            nsf_pkg::PH_CK2: begin
                n_hex    = {r_hex[BW-1:4], nsf_pkg::hex_nibble(b)};
                n_phase  = nsf_pkg::PH_IDLE;
                n_status = (n_hex == r_xor) ? nsf_pkg::ST_CK_OK : nsf_pkg::ST_CK_BAD;
                n_class  = nsf_pkg::CL_CKSUM;
                n_idx    = 8'd1;
            end
            default: begin
                n_phase = nsf_pkg::PH_IDLE;
            end
        endcase
        // Command store packed first character in the low byte
        for (int i = 0; i < nsf_pkg::CMD_DEPTH; i++) begin
            n_word[i*BW +: BW] = n_cmd[i];
        end
    end

    // Framing state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= nsf_pkg::PH_IDLE;
            r_xor      <= '0;
            r_hex      <= '0;
            r_pos      <= '0;
            r_skip_cnt <= '0;
            r_cmd_len  <= '0;
            r_skip_cfg <= '0;
            for (int i = 0; i < nsf_pkg::CMD_DEPTH; i++) begin
                r_cmd[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_skip_cfg <= i_cfg.skip_after_start;
            end
            if (in_xfer) begin
                r_phase    <= n_phase;
                r_xor      <= n_xor;
                r_hex      <= n_hex;
                r_pos      <= n_pos;
                r_skip_cnt <= n_skip_cnt;
                r_cmd_len  <= n_cmd_len;
                r_cmd      <= n_cmd;
            end
        end
    end

    // Result register: valid flag under reset, payload loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status <= n_status;
            r_class  <= n_class;
            r_idx    <= n_idx;
            r_word   <= n_word;
        end
    end

    // Checksum and length fields show the state after the byte, held in the state registers
    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_status;
    assign o_out.byte_class        = r_class;
    assign o_out.field_index       = r_idx;
    assign o_out.command_word      = r_word;
    assign o_out.command_length    = r_cmd_len;
    assign o_out.computed_checksum = r_xor;
    assign o_out.received_checksum = r_hex;

`ifndef SYNTHESIS
    // A checksum verdict only comes with the second checksum digit
    a_verdict_on_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == nsf_pkg::ST_CK_OK ||
                         o_out.status == nsf_pkg::ST_CK_BAD))
        |-> (o_out.byte_class == nsf_pkg::CL_CKSUM && o_out.field_index == 8'd1))
        else $error("checksum verdict on a byte that is not the second digit");

    // Overflow is only raised by a command or data character
    a_overflow_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == nsf_pkg::ST_OVERFLOW)
        |-> (o_out.byte_class == nsf_pkg::CL_CMD || o_out.byte_class == nsf_pkg::CL_DATA))
        else $error("overflow reported on a byte of the wrong class");

    // Outside a sentence, any byte other than the start character is ignored
    a_idle_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_phase == nsf_pkg::PH_IDLE && i_in.rx_byte != nsf_pkg::CH_START)
        |=> (o_out.valid && o_out.status == nsf_pkg::ST_IDLE &&
             o_out.byte_class == nsf_pkg::CL_IGNORED))
        else $error("byte outside a sentence not reported as ignored");

    // Stored command never exceeds its limit
    a_cmd_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_len <= nsf_pkg::LEN_W'(CMD_MAX))
        else $error("command length beyond its limit");
`endif

endmodule

`default_nettype wire
